FILE: hw/rtl/ftss_pkg.sv
// ----------------------------------------------------------------------------
// Flex test stepper sequencer package
// Phase, command and end-cause codes and the control word that the core hands
// to the top level with each result.
// ----------------------------------------------------------------------------
package ftss_pkg;

  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_RAISING   = 2'd1;
  localparam logic [1:0] PH_MEASURING = 2'd2;
  localparam logic [1:0] PH_LOWERING  = 2'd3;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  localparam logic [1:0] CAUSE_NONE = 2'd0;
  localparam logic [1:0] CAUSE_DISP = 2'd1;
  localparam logic [1:0] CAUSE_LOAD = 2'd2;

  localparam logic CFG_MAX_COUNT  = 1'b0;
  localparam logic CFG_LOAD_LIMIT = 1'b1;

  localparam int MAX_COUNT_RST  = 7500;
  localparam int LOAD_LIMIT_RST = 50000;

  typedef struct packed {
    logic       step_level;
    logic       dir_level;
    logic       motor_awake;
    logic [1:0] phase;
    logic       finished;
    logic [1:0] end_cause;
  } ctrl_t;

endpackage

FILE: hw/rtl/flex_test_stepper_sequencer_top.sv
// ----------------------------------------------------------------------------
// Flex test stepper sequencer top level
// Stream wrapper with an input register and a result register around the
// sequencer core.
// ----------------------------------------------------------------------------
// Each accepted item is one pass of the bend-test control loop and yields
// exactly one result item via the input and result registers. One item is
// accepted in every cycle while the output does not stall: the item is held
// in an input register, the core works the whole pass against its state
// registers, and the result register holds a result until it is taken,
// stalling the input side meanwhile. The sustained rate is one item per clock
// while results are taken. Configuration writes take effect at the clock edge
// of the write and are meant to happen only while no item is in flight.
module flex_test_stepper_sequencer_top #(
  parameter int SAMPLE_BITS = 24,
  parameter int COUNT_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [((COUNT_BITS > SAMPLE_BITS + 1) ? COUNT_BITS : SAMPLE_BITS + 1)-1:0]
                              cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // command, upper_press, lower_press, tick, left_valid, left_sample,
  // right_valid, right_sample, zero fill.
  input  logic [((2 * SAMPLE_BITS + 7 + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // step_level, dir_level, motor_awake, phase, finished, displacement,
  // end_cause, zero fill.
  output logic [((COUNT_BITS + 8 + 7) / 8) * 8 - 1:0] m_axis_tdata
);
  import ftss_pkg::*;

  localparam int CFG_W = (COUNT_BITS > SAMPLE_BITS + 1) ? COUNT_BITS : SAMPLE_BITS + 1;
  localparam int IN_W  = ((2 * SAMPLE_BITS + 7 + 7) / 8) * 8;
  localparam int OUT_W = ((COUNT_BITS + 8 + 7) / 8) * 8;
  localparam int RES_W = COUNT_BITS + 8;

  logic                  in_valid_q;
  logic [IN_W-1:0]       in_q;
  logic                  out_valid_q;
  logic [RES_W-1:0]      out_q;
  logic                  advance;
  logic                  fire;
  ctrl_t                 ctrl;
  logic [COUNT_BITS-1:0] displacement;

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= s_axis_tdata;
    end
  end

  ftss_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .CFG_W       (CFG_W)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fire_i         (fire),
    .command_i      (in_q[1:0]),
    .upper_press_i  (in_q[2]),
    .lower_press_i  (in_q[3]),
    .tick_i         (in_q[4]),
    .left_valid_i   (in_q[5]),
    .left_sample_i  (in_q[6 +: SAMPLE_BITS]),
    .right_valid_i  (in_q[6 + SAMPLE_BITS]),
    .right_sample_i (in_q[7 + SAMPLE_BITS +: SAMPLE_BITS]),
    .ctrl_o         (ctrl),
    .displacement_o (displacement)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= {ctrl.end_cause, displacement, ctrl.finished, ctrl.phase,
                ctrl.motor_awake, ctrl.dir_level, ctrl.step_level};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(out_q);

endmodule

FILE: hw/rtl/ftss_core.sv
// ----------------------------------------------------------------------------
// Flex test stepper sequencer core
// Holds the test state and configuration and works one control-loop pass per
// fired item combinationally against its state registers.
// ----------------------------------------------------------------------------
module ftss_core #(
  parameter int SAMPLE_BITS = 24,
  parameter int COUNT_BITS  = 16,
  parameter int CFG_W       = 25
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic                   fire_i,
  input  logic [1:0]             command_i,
  input  logic                   upper_press_i,
  input  logic                   lower_press_i,
  input  logic                   tick_i,
  input  logic                   left_valid_i,
  input  logic [SAMPLE_BITS-1:0] left_sample_i,
  input  logic                   right_valid_i,
  input  logic [SAMPLE_BITS-1:0] right_sample_i,
  output ftss_pkg::ctrl_t        ctrl_o,
  output logic [COUNT_BITS-1:0]  displacement_o
);
  import ftss_pkg::*;

  logic [COUNT_BITS-1:0]    max_count_q;
  logic [SAMPLE_BITS:0]     load_limit_q;
  logic [1:0]               phase_q, phase_d;
  logic [COUNT_BITS-1:0]    count_q, count_d;
  logic [SAMPLE_BITS-1:0]   left_q, left_d;
  logic [SAMPLE_BITS-1:0]   right_q, right_d;
  logic                     step_q, step_d;
  logic                     dir_q, dir_d;
  logic                     awake_q, awake_d;
  logic [1:0]               cause;
  logic signed [SAMPLE_BITS:0] load_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_count_q  <= COUNT_BITS'(MAX_COUNT_RST);
      load_limit_q <= (SAMPLE_BITS + 1)'(LOAD_LIMIT_RST);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAX_COUNT:  max_count_q  <= cfg_data_i[COUNT_BITS-1:0];
        CFG_LOAD_LIMIT: load_limit_q <= cfg_data_i[SAMPLE_BITS:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    step_d  = step_q;
    dir_d   = dir_q;
    awake_d = awake_q;
    cause   = CAUSE_NONE;

    case (command_i)
      CMD_START: begin
        phase_d = PH_RAISING;
        awake_d = 1'b1;
        dir_d   = 1'b0;
        step_d  = 1'b0;
      end
      CMD_STOP: begin
        phase_d = PH_IDLE;
        awake_d = 1'b0;
      end
      default: ;
    endcase

    if (upper_press_i && phase_d == PH_RAISING) begin
      phase_d = PH_MEASURING;
      count_d = '0;
    end

    if (lower_press_i && phase_d == PH_LOWERING) begin
      phase_d = PH_IDLE;
      awake_d = 1'b0;
    end

    if (tick_i) begin
      if (phase_d != PH_IDLE) begin
        step_d = ~step_d;
      end
      if (phase_d == PH_MEASURING) begin
        if (count_d != '1) begin
          count_d = count_d + 1'b1;
        end
        if (count_d > max_count_q) begin
          phase_d = PH_LOWERING;
          awake_d = 1'b1;
          dir_d   = 1'b1;
          step_d  = 1'b0;
          cause   = CAUSE_DISP;
        end
      end
    end

    left_d  = left_valid_i  ? left_sample_i  : left_q;
    right_d = right_valid_i ? right_sample_i : right_q;
    load_sum = $signed({left_d[SAMPLE_BITS-1], left_d})
             + $signed({right_d[SAMPLE_BITS-1], right_d});

    if (load_sum > $signed(load_limit_q) && phase_d == PH_MEASURING) begin
      phase_d = PH_LOWERING;
      awake_d = 1'b1;
      dir_d   = 1'b1;
      step_d  = 1'b0;
      cause   = CAUSE_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
      left_q  <= '0;
      right_q <= '0;
      step_q  <= 1'b0;
      dir_q   <= 1'b0;
      awake_q <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      left_q  <= left_d;
      right_q <= right_d;
      step_q  <= step_d;
      dir_q   <= dir_d;
      awake_q <= awake_d;
    end
  end

  assign ctrl_o.step_level  = step_d;
  assign ctrl_o.dir_level   = dir_d;
  assign ctrl_o.motor_awake = awake_d;
  assign ctrl_o.phase       = phase_d;
  assign ctrl_o.finished    = (phase_d == PH_IDLE);
  assign ctrl_o.end_cause   = cause;
  assign displacement_o     = count_d;

`ifndef SYNTHESIS
  a_awake_tracks_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    awake_q == (phase_q != PH_IDLE))
    else $error("driver enable disagrees with phase");

  a_end_enters_lowering: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && cause != CAUSE_NONE) |=>
      (phase_q == PH_LOWERING && dir_q && awake_q && !step_q))
    else $error("end of measuring did not start lowering");

  a_count_holds_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(count_q) && $stable(phase_q))
    else $error("state changed without an item");

  a_measure_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && phase_d == PH_MEASURING && phase_q != PH_MEASURING) |->
      (upper_press_i && (phase_q == PH_RAISING || command_i == CMD_START)))
    else $error("measuring entered without an upper limit press in raising");
`endif

endmodule
